// ===== design/sfs_pkg.sv =====
// sfs_pkg: shared types and constants of the sprite frame sequencer
// no dependencies; used by every design file by scoped name
package sfs_pkg;

  // operation codes of an input beat
  typedef enum logic [2:0] {
    OP_TICK,
    OP_PLAY_RANGE,
    OP_PLAY_LIST,
    OP_PAUSE,
    OP_STOP,
    OP_SELECT,
    OP_WRITE_ENTRY,
    OP_RETARGET
  } op_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_START_FRAME,
    REG_END_FRAME,
    REG_LOOP_LIMIT,
    REG_FRAME_PERIOD,
    REG_SHEET_COLUMNS,
    REG_CELL_WIDTH,
    REG_CELL_HEIGHT
  } cfg_reg_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_READ,
    ST_DIV_INIT,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned ACC_W      = 25;
  localparam int unsigned LOOPS_W    = 9;
  localparam int unsigned RECT_W     = 20;

  localparam logic [ACC_W-1:0]   ACC_MAX      = 25'h1FF_FFFF;
  localparam logic [LOOPS_W-1:0] LOOPS_MAX    = 9'd511;
  localparam logic [LOOPS_W-1:0] LOOP_FOREVER = 9'h1FF;
  localparam logic [2:0]         DIV_LAST     = 3'd7;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] elapsed_us;
    logic        flag_value;
    logic [7:0]  frame_or_entry;
    logic [3:0]  entry_slot;
    logic [4:0]  list_count;
  } in_t;

  typedef struct packed {
    logic [19:0] rect_x;
    logic [19:0] rect_y;
    logic [7:0]  frame_position;
    logic        playing;
    logic        stopped;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic check;
    logic read;
    logic div_init;
    logic div_step;
    logic mul;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tick_run;
    logic select;
    logic advance;
    logic list_mode;
    logic div_last;
  } sts_t;

endpackage

// ===== design/sfs_ctrl.sv =====
// sfs_ctrl: sequencing state machine and output beat valid
// depends on sfs_pkg
module sfs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  sfs_pkg::sts_t sts_i,
  output sfs_pkg::cmd_t cmd_o
);

  sfs_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sfs_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sfs_pkg::ST_EXEC;
      end
      sfs_pkg::ST_EXEC: begin
        if (sts_i.tick_run)    state_d = sfs_pkg::ST_CHECK;
        else if (sts_i.select) state_d = sfs_pkg::ST_DIV_INIT;
        else                   state_d = sfs_pkg::ST_DONE;
      end
      sfs_pkg::ST_CHECK: begin
        if (!sts_i.advance)      state_d = sfs_pkg::ST_DONE;
        else if (sts_i.list_mode) state_d = sfs_pkg::ST_READ;
        else                     state_d = sfs_pkg::ST_DIV_INIT;
      end
      sfs_pkg::ST_READ:     state_d = sfs_pkg::ST_DIV_INIT;
      sfs_pkg::ST_DIV_INIT: state_d = sfs_pkg::ST_DIV;
      sfs_pkg::ST_DIV: begin
        if (sts_i.div_last) state_d = sfs_pkg::ST_MUL;
      end
      sfs_pkg::ST_MUL:      state_d = sfs_pkg::ST_DONE;
      sfs_pkg::ST_DONE: begin
        if (out_free) state_d = sfs_pkg::ST_IDLE;
      end
      default:              state_d = sfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == sfs_pkg::ST_IDLE) && in_valid_i;
    cmd_o.exec     = (state_q == sfs_pkg::ST_EXEC);
    cmd_o.check    = (state_q == sfs_pkg::ST_CHECK);
    cmd_o.read     = (state_q == sfs_pkg::ST_READ);
    cmd_o.div_init = (state_q == sfs_pkg::ST_DIV_INIT);
    cmd_o.div_step = (state_q == sfs_pkg::ST_DIV);
    cmd_o.mul      = (state_q == sfs_pkg::ST_MUL);
    cmd_o.out_load = (state_q == sfs_pkg::ST_DONE) && out_free;
    in_ready_o     = (state_q == sfs_pkg::ST_IDLE);
    out_valid_d    = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/sfs_datapath.sv =====
// sfs_datapath: config registers, animation state, frame list memory,
// serial divider for the sheet column split and rectangle multipliers
// depends on sfs_pkg
module sfs_datapath #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  sfs_pkg::in_t                        in_data_i,
  output sfs_pkg::out_t                       out_data_o,
  input  sfs_pkg::cmd_t                       cmd_i,
  output sfs_pkg::sts_t                       sts_o
);

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned LW = $clog2(LIST_DEPTH + 1);
  localparam logic [8:0]  DEPTH9 = 9'(LIST_DEPTH);

  // configuration
  logic [7:0]  start_q, end_q, cols_q;
  logic [8:0]  limit_q;
  logic [23:0] period_q;
  logic [11:0] cw_q, ch_q;

  // animation state
  logic [7:0]                  pos_q;
  logic [sfs_pkg::ACC_W-1:0]   acc_q;
  logic [sfs_pkg::LOOPS_W-1:0] loops_q;
  logic                        paused_q, stopped_q, playing_q, list_mode_q;
  logic [LW-1:0]               list_len_q;
  logic [sfs_pkg::RECT_W-1:0]  rect_x_q, rect_y_q;

  // payload
  sfs_pkg::in_t  in_q;
  sfs_pkg::out_t out_q;
  logic [7:0]    src_q, rem_q, quo_q;
  logic [2:0]    div_cnt_q;
  logic [7:0]    mem_q [LIST_DEPTH];

  sfs_pkg::op_e                op;
  logic [25:0]                 acc_sum;
  logic [sfs_pkg::ACC_W-1:0]   acc_sat;
  logic [8:0]                  pos_inc, slot9, cnt9, cnt_clamp;
  logic                        range_wrap, list_wrap, exceeded, slot_ok, pos_ok;
  logic [sfs_pkg::LOOPS_W-1:0] loops_inc;
  logic [7:0]                  range_pos, cols;
  logic [8:0]                  rem_try;
  logic                        rem_ge;
  logic [19:0]                 prod_x, prod_y;

  assign op      = sfs_pkg::op_e'(in_q.operation);
  assign acc_sum = {1'b0, acc_q} + 26'(in_q.elapsed_us);
  assign acc_sat = acc_sum[25] ? sfs_pkg::ACC_MAX : acc_sum[24:0];
  assign pos_inc = {1'b0, pos_q} + 9'd1;
  assign cols    = (cols_q == 8'd0) ? 8'd1 : cols_q;

  assign range_wrap = pos_inc > {1'b0, end_q};
  assign list_wrap  = pos_inc >= 9'(list_len_q);
  assign loops_inc  = (loops_q == sfs_pkg::LOOPS_MAX) ? loops_q : loops_q + 9'd1;
  // a negative limit other than forever stops on any completed loop
  assign exceeded   = (limit_q != sfs_pkg::LOOP_FOREVER) &&
                      (limit_q[8] || (loops_inc > {1'b0, limit_q[7:0]}));
  assign range_pos  = !range_wrap ? pos_inc[7:0] : (exceeded ? end_q : start_q);

  assign slot9   = 9'(in_q.entry_slot);
  assign slot_ok = slot9 < DEPTH9;
  assign pos_ok  = {1'b0, pos_q} < DEPTH9;

  always_comb begin
    cnt9      = 9'(in_q.list_count);
    cnt_clamp = cnt9;
    if (cnt9 == 9'd0)   cnt_clamp = 9'd1;
    if (cnt9 > DEPTH9)  cnt_clamp = DEPTH9;
  end

  // one restoring step per cycle, msb first
  assign rem_try = {rem_q, quo_q[7]};
  assign rem_ge  = rem_try >= {1'b0, cols};
  assign prod_x  = {12'd0, rem_q} * {8'd0, cw_q};
  assign prod_y  = {12'd0, quo_q} * {8'd0, ch_q};

  assign sts_o.tick_run  = (op == sfs_pkg::OP_TICK) && !paused_q && !stopped_q;
  assign sts_o.select    = (op == sfs_pkg::OP_SELECT);
  assign sts_o.advance   = acc_q > {1'b0, period_q};
  assign sts_o.list_mode = list_mode_q;
  assign sts_o.div_last  = (div_cnt_q == sfs_pkg::DIV_LAST);

  assign out_data_o = out_q;

  // configuration and animation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= 8'd0;
      end_q       <= 8'd0;
      limit_q     <= sfs_pkg::LOOP_FOREVER;
      period_q    <= 24'd100000;
      cols_q      <= 8'd1;
      cw_q        <= 12'd16;
      ch_q        <= 12'd16;
      pos_q       <= 8'd0;
      acc_q       <= '0;
      loops_q     <= '0;
      paused_q    <= 1'b0;
      stopped_q   <= 1'b0;
      playing_q   <= 1'b0;
      list_mode_q <= 1'b0;
      list_len_q  <= LW'(1);
      rect_x_q    <= '0;
      rect_y_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (sfs_pkg::cfg_reg_e'(cfg_idx_i))
          sfs_pkg::REG_START_FRAME:   start_q  <= cfg_wdata_i[7:0];
          sfs_pkg::REG_END_FRAME:     end_q    <= cfg_wdata_i[7:0];
          sfs_pkg::REG_LOOP_LIMIT:    limit_q  <= cfg_wdata_i[8:0];
          sfs_pkg::REG_FRAME_PERIOD:  period_q <= cfg_wdata_i;
          sfs_pkg::REG_SHEET_COLUMNS: cols_q   <= cfg_wdata_i[7:0];
          sfs_pkg::REG_CELL_WIDTH:    cw_q     <= cfg_wdata_i[11:0];
          sfs_pkg::REG_CELL_HEIGHT:   ch_q     <= cfg_wdata_i[11:0];
          default: ;
        endcase
      end
      if (cmd_i.exec) begin
        case (op)
          sfs_pkg::OP_TICK: begin
            if (paused_q || stopped_q) playing_q <= 1'b0;
            else                       acc_q     <= acc_sat;
          end
          sfs_pkg::OP_PLAY_RANGE: begin
            acc_q       <= {1'b0, period_q};
            pos_q       <= start_q;
            loops_q     <= '0;
            list_mode_q <= 1'b0;
            paused_q    <= 1'b0;
            stopped_q   <= 1'b0;
            playing_q   <= 1'b1;
          end
          sfs_pkg::OP_PLAY_LIST: begin
            list_mode_q <= 1'b1;
            list_len_q  <= LW'(cnt_clamp);
            pos_q       <= 8'd0;
            loops_q     <= '0;
            paused_q    <= 1'b0;
            stopped_q   <= 1'b0;
            playing_q   <= 1'b1;
          end
          sfs_pkg::OP_PAUSE: paused_q <= in_q.flag_value;
          sfs_pkg::OP_STOP: begin
            stopped_q <= in_q.flag_value;
            if (in_q.flag_value) playing_q <= 1'b0;
          end
          sfs_pkg::OP_SELECT:      paused_q <= 1'b1;
          sfs_pkg::OP_WRITE_ENTRY: ;
          default: begin
            acc_q <= '0;
            pos_q <= start_q;
          end
        endcase
      end
      if (cmd_i.check && sts_o.advance) begin
        acc_q <= '0;
        if (list_mode_q) begin
          if (list_wrap) begin
            loops_q <= loops_inc;
            if (exceeded) stopped_q <= 1'b1;
            pos_q <= 8'd0;
          end else begin
            pos_q <= pos_inc[7:0];
          end
        end else begin
          pos_q <= range_pos;
          if (range_wrap) begin
            loops_q <= loops_inc;
            if (exceeded) begin
              loops_q   <= '0;
              stopped_q <= 1'b1;
            end
          end
        end
      end
      if (cmd_i.mul) begin
        rect_x_q <= prod_x;
        rect_y_q <= prod_y;
      end
    end
  end

  // item, divider and output beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_data_i;
    if (cmd_i.exec) src_q <= in_q.frame_or_entry;
    if (cmd_i.check) src_q <= range_pos;
    if (cmd_i.read) src_q <= pos_ok ? mem_q[pos_q[AW-1:0]] : 8'd0;
    if (cmd_i.div_init) begin
      rem_q     <= 8'd0;
      quo_q     <= src_q;
      div_cnt_q <= 3'd0;
    end
    if (cmd_i.div_step) begin
      rem_q     <= rem_ge ? 8'(rem_try - {1'b0, cols}) : rem_try[7:0];
      quo_q     <= {quo_q[6:0], rem_ge};
      div_cnt_q <= div_cnt_q + 3'd1;
    end
    if (cmd_i.out_load) begin
      out_q.rect_x         <= rect_x_q;
      out_q.rect_y         <= rect_y_q;
      out_q.frame_position <= pos_q;
      out_q.playing        <= playing_q;
      out_q.stopped        <= stopped_q;
    end
  end

  // frame list table
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (op == sfs_pkg::OP_WRITE_ENTRY) && slot_ok) begin
      mem_q[slot9[AW-1:0]] <= in_q.frame_or_entry;
    end
  end

endmodule

// ===== design/sprite_frame_sequencer.sv =====
// sequence: plain commands run exec then done; a tick that advances runs exec,
// check, read (list mode only), div init, div, mul, done; select frame runs
// exec, div init, div, mul, done; done waits for a free output register
// throughput: one item at a time; the 8-step serial column divider dominates
// reset: asynchronous active low, clears state and loads register defaults;
// the frame list table is not cleared and reads are valid only once written
module sprite_frame_sequencer #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sfs_pkg::in_t                   in_data_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sfs_pkg::out_t                  out_data_o,
  // register writes, to be made by the user only while idle; the block does not enforce it
  input  logic                           cfg_we_i,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  // command and status between controller and datapath
  sfs_pkg::cmd_t cmd;
  sfs_pkg::sts_t sts;

  // controller walks: exec, then for a running tick the period check,
  // then list table read, column divide and rectangle multiply as needed;
  // the finished beat waits in an output register until taken
  sfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath holds config, position, accumulator, loop count, flags,
  // the frame list and the rectangle
  sfs_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== design/sfs_checker.sv =====
// sfs_checker: port-level assertions for the sprite frame sequencer
// depends on sfs_pkg; bound to sprite_frame_sequencer
module sfs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input sfs_pkg::out_t out_data_o
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // one item in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while another is in work");

  // rectangle within sheet bounds
  a_rect_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.rect_x <= 20'd1044225) &&
                    (out_data_o.rect_y <= 20'd1044225))
    else $error("rectangle out of range");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (.*);
